/* hw/rtl/pnm_stream_to_rgba_decoder_macros.svh */
// assertion macros for the pnm stream decoder
// used by the top level only; no other dependencies
`ifndef PNM_STREAM_TO_RGBA_DECODER_MACROS_SVH
`define PNM_STREAM_TO_RGBA_DECODER_MACROS_SVH

// implication checked every clock edge outside reset
`define PNM_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error(msg);

// implication with the consequent checked in the following cycle
`define PNM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error(msg);

`endif

/* hw/rtl/pnm_pkg.sv */
// shared types and constants for the pnm stream decoder
// no dependencies
package pnm_pkg;

	localparam int unsigned SAMPLE_BITS_DEF = 16;
	localparam int unsigned QDEPTH = 4;

	localparam logic [1:0] KIND_HDR = 2'd0;
	localparam logic [1:0] KIND_PIX = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_MAGIC  = 3'd1;
	localparam logic [2:0] ERR_HDRNUM = 3'd2;
	localparam logic [2:0] ERR_SAMPLE = 3'd3;
	localparam logic [2:0] ERR_EARLY  = 3'd4;

	// result of the front end for one step
	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_HDR  = 2'd1;
	localparam logic [1:0] OP_SAMP = 2'd2;
	localparam logic [1:0] OP_ERR  = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        last_pixel;
		logic [2:0]  error_code;
		logic        last_of_run;
	} out_item_t;

	// one job handed from front to back
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] sample;
		logic [15:0] maxv;
		logic        emit;
		logic [1:0]  chan;
		logic        last_pix;
		logic        last_run;
		logic [2:0]  err;
		logic [15:0] w;
		logic [15:0] h;
	} job_t;

endpackage

/* hw/rtl/pnm_front.sv */
// front end: parses the byte stream and issues jobs (header, sample, error)
// depends on pnm_pkg; up to two jobs per byte, issued one per cycle while jready is high
module pnm_front #(
	parameter int unsigned SAMPLE_BITS = pnm_pkg::SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  pnm_pkg::in_item_t in_item,
	output logic              jvalid,
	input  logic              jready,
	output pnm_pkg::job_t     job
);

	localparam logic [3:0] PH_P = 4'd0, PH_DIGIT = 4'd1, PH_W = 4'd2, PH_H = 4'd3,
		PH_MAX = 4'd4, PH_ASCII = 4'd5, PH_BIN = 4'd6, PH_DONE = 4'd7, PH_FAIL = 4'd8;
	localparam logic [16:0] MAXV_LIM = 17'((64'd1 << SAMPLE_BITS) - 64'd1);

	logic [3:0]  phase_q;
	logic [1:0]  fmt_q;
	logic [15:0] w_q, h_q, maxv_q;
	logic [16:0] tok_q;
	logic        started_q, digit_q, neg_q, bad_q;
	logic        cmt_q;
	logic [1:0]  chan_q;
	logic [7:0]  hi_q;
	logic [31:0] left_q;

	// pixel count product, split over two 16x16 multiplies is not needed: one 16x16
	logic [31:0] area;
	assign area = w_q * h_q;

	// holding register for the second job of a byte
	logic  pend_q;
	pnm_pkg::job_t pend_job_q;

	// combinational next state and up to two jobs
	logic [3:0]  ph_n;
	logic [1:0]  fmt_n, chan_n;
	logic [15:0] w_n, h_n, maxv_n;
	logic [16:0] tok_n;
	logic        st_n, dg_n, ng_n, bd_n, cmt_n;
	logic [7:0]  hi_n;
	logic [31:0] left_n;
	pnm_pkg::job_t j0, j1;
	logic        v0, v1;

	logic [7:0] b;
	logic eof, ws, is_hash, ok, fin_now, tv_ok;
	logic [16:0] tv;
	logic [20:0] acc;

	always_comb begin
		ph_n = phase_q; fmt_n = fmt_q; w_n = w_q; h_n = h_q; maxv_n = maxv_q;
		tok_n = tok_q; st_n = started_q; dg_n = digit_q; ng_n = neg_q; bd_n = bad_q;
		cmt_n = cmt_q; chan_n = chan_q; hi_n = hi_q; left_n = left_q;
		j0 = '0; j1 = '0; v0 = 1'b0; v1 = 1'b0;
		b = in_item.in_byte; eof = in_item.end_of_file;
		ws = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
		is_hash = (b == 8'h23);
		fin_now = 1'b0; tv = '0; ok = 1'b0; tv_ok = 1'b0; acc = '0;

		// byte handling
		unique case (phase_q)
			PH_P: begin
				if (b == 8'h50) ph_n = PH_DIGIT;
				else begin
					v0 = 1'b1; j0.op = pnm_pkg::OP_ERR; j0.err = pnm_pkg::ERR_MAGIC;
					ph_n = PH_FAIL;
				end
			end
			PH_DIGIT: begin
				ph_n = PH_W;
				if (b == 8'h32) fmt_n = 2'd0;
				else if (b == 8'h33) fmt_n = 2'd1;
				else if (b == 8'h35) fmt_n = 2'd2;
				else if (b == 8'h36) fmt_n = 2'd3;
				else begin
					v0 = 1'b1; j0.op = pnm_pkg::OP_ERR; j0.err = pnm_pkg::ERR_MAGIC;
					ph_n = PH_FAIL;
				end
			end
			PH_W, PH_H, PH_MAX, PH_ASCII: begin
				if (cmt_q) begin
					if (b == 8'd10 || b == 8'd13) cmt_n = 1'b0;
				end else if (ws || is_hash) begin
					if (started_q) begin
						if (phase_q == PH_MAX && fmt_q[1] && is_hash) begin
							tok_n = '0; st_n = 1'b0; dg_n = 1'b0; ng_n = 1'b0; bd_n = 1'b0;
							v0 = 1'b1; j0.op = pnm_pkg::OP_ERR; j0.err = pnm_pkg::ERR_HDRNUM;
							ph_n = PH_FAIL;
						end else begin
							fin_now = 1'b1;
						end
					end
				end else if (!started_q && (b == 8'h2B || b == 8'h2D)) begin
					st_n = 1'b1;
					if (b == 8'h2D) ng_n = 1'b1;
				end else if (b >= 8'h30 && b <= 8'h39) begin
					st_n = 1'b1; dg_n = 1'b1;
					acc = {tok_q, 3'b0} + {3'b0, tok_q, 1'b0} + 21'(b - 8'h30);
					tok_n = (acc > 21'd65536) ? 17'd65536 : acc[16:0];
				end else begin
					st_n = 1'b1; bd_n = 1'b1;
				end
			end
			PH_BIN: begin
				if (maxv_q > 16'd255 && !started_q) begin
					hi_n = b; st_n = 1'b1;
				end else begin
					v0 = 1'b1; j0.op = pnm_pkg::OP_SAMP;
					j0.sample = (maxv_q > 16'd255) ? {hi_q, b} : {8'd0, b};
					st_n = 1'b0;
				end
			end
			default: ;
		endcase

		// eof with a token still open finishes it too
		if (eof && !fin_now && phase_q >= PH_W && phase_q <= PH_ASCII && !cmt_n && st_n
			&& ph_n != PH_FAIL)
			fin_now = 1'b1;

		// token completion (never together with a byte-level job)
		if (fin_now) begin
			tv = tok_n;
			tv_ok = dg_n && !bd_n && tv <= 17'd65535 && !(ng_n && tv != 17'd0);
			ok = tv_ok && tv != 17'd0;
			tok_n = '0; st_n = 1'b0; dg_n = 1'b0; ng_n = 1'b0; bd_n = 1'b0;
			priority case (phase_q)
				PH_W: begin
					if (ok) begin w_n = tv[15:0]; ph_n = PH_H; end
					else begin
						v0 = 1'b1; j0.op = pnm_pkg::OP_ERR; j0.err = pnm_pkg::ERR_HDRNUM;
						ph_n = PH_FAIL;
					end
				end
				PH_H: begin
					if (ok) begin h_n = tv[15:0]; ph_n = PH_MAX; end
					else begin
						v0 = 1'b1; j0.op = pnm_pkg::OP_ERR; j0.err = pnm_pkg::ERR_HDRNUM;
						ph_n = PH_FAIL;
					end
				end
				PH_MAX: begin
					if (ok && tv <= MAXV_LIM) begin
						maxv_n = tv[15:0]; left_n = area; chan_n = 2'd0;
						v0 = 1'b1; j0.op = pnm_pkg::OP_HDR; j0.w = w_q; j0.h = h_q;
						ph_n = fmt_q[1] ? PH_BIN : PH_ASCII;
					end else begin
						v0 = 1'b1; j0.op = pnm_pkg::OP_ERR; j0.err = pnm_pkg::ERR_HDRNUM;
						ph_n = PH_FAIL;
					end
				end
				default: begin
					if (tv_ok) begin
						v0 = 1'b1; j0.op = pnm_pkg::OP_SAMP; j0.sample = tv[15:0];
					end else begin
						v0 = 1'b1; j0.op = pnm_pkg::OP_ERR; j0.err = pnm_pkg::ERR_SAMPLE;
						ph_n = PH_FAIL;
					end
				end
			endcase
		end

		// sample bookkeeping: channel and pixel count
		if (v0 && j0.op == pnm_pkg::OP_SAMP) begin
			j0.maxv = maxv_n; j0.chan = chan_n;
			if (fmt_n[0] && chan_n != 2'd2) begin
				chan_n = chan_n + 2'd1;
			end else begin
				j0.emit = 1'b1; chan_n = 2'd0; left_n = left_n - 32'd1;
				if (left_n == 32'd0) begin j0.last_pix = 1'b1; ph_n = PH_DONE; end
			end
		end

		// end of file: early end error unless done or failed, then back to reset
		if (eof) begin
			if (ph_n != PH_DONE && ph_n != PH_FAIL) begin
				if (v0) begin
					v1 = 1'b1; j1.op = pnm_pkg::OP_ERR; j1.err = pnm_pkg::ERR_EARLY;
				end else begin
					v0 = 1'b1; j0.op = pnm_pkg::OP_ERR; j0.err = pnm_pkg::ERR_EARLY;
				end
			end
			ph_n = PH_P; fmt_n = '0; w_n = '0; h_n = '0; maxv_n = '0; tok_n = '0;
			st_n = 1'b0; dg_n = 1'b0; ng_n = 1'b0; bd_n = 1'b0; cmt_n = 1'b0;
			chan_n = '0; hi_n = '0; left_n = '0;
		end

		// comment start after token handling
		if (!eof && !cmt_q && is_hash && ph_n >= PH_W && ph_n <= PH_ASCII
			&& phase_q >= PH_W && phase_q <= PH_ASCII)
			cmt_n = 1'b1;

		// mark the last job of this byte
		if (v1) j1.last_run = 1'b1;
		else if (v0) j0.last_run = 1'b1;
	end

	// input is taken only when no second job is pending and the first can go
	assign full   = pend_q || !jready;
	assign jvalid = pend_q || (push && v0);
	assign job    = pend_q ? pend_job_q : j0;

	logic acc_in;
	assign acc_in = push && !full;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_P; fmt_q <= '0; w_q <= '0; h_q <= '0; maxv_q <= '0;
			tok_q <= '0; started_q <= 1'b0; digit_q <= 1'b0; neg_q <= 1'b0; bad_q <= 1'b0;
			cmt_q <= 1'b0; chan_q <= '0; hi_q <= '0; left_q <= '0; pend_q <= 1'b0;
		end else begin
			if (pend_q && jready) pend_q <= 1'b0;
			if (acc_in) begin
				phase_q <= ph_n; fmt_q <= fmt_n; w_q <= w_n; h_q <= h_n; maxv_q <= maxv_n;
				tok_q <= tok_n; started_q <= st_n; digit_q <= dg_n; neg_q <= ng_n;
				bad_q <= bd_n; cmt_q <= cmt_n; chan_q <= chan_n; hi_q <= hi_n;
				left_q <= left_n;
				pend_q <= v1;
			end
		end
	end

	// second job payload
	always_ff @(posedge clk) begin
		if (acc_in) pend_job_q <= j1;
	end

endmodule

/* hw/rtl/pnm_queue.sv */
// short job queue between parser and scaler
// depends on pnm_pkg
module pnm_queue #(
	parameter int unsigned DEPTH = pnm_pkg::QDEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wvalid,
	output logic          wready,
	input  pnm_pkg::job_t wdata,
	output logic          rvalid,
	input  logic          rready,
	output pnm_pkg::job_t rdata
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	pnm_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          wr, rd;

	assign wready = cnt_q != (AW+1)'(DEPTH);
	assign rvalid = cnt_q != '0;
	assign rdata  = mem_q[rp_q];
	assign wr = wvalid && wready;
	assign rd = rvalid && rready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

endmodule

/* hw/rtl/pnm_back.sv */
// back end: scales samples with a radix-2 divider and builds result items
// depends on pnm_pkg
module pnm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               jvalid,
	output logic               jready,
	input  pnm_pkg::job_t      job,
	output logic               empty,
	input  logic               pop,
	output pnm_pkg::out_item_t result
);

	localparam logic [1:0] ST_IDLE = 2'd0, ST_DIV = 2'd1, ST_OUT = 2'd2;

	logic [1:0]  st_q;
	logic [3:0]  cnt_q;
	logic [24:0] rem_q;
	logic [15:0] den_q;
	logic [7:0]  quo_q;
	pnm_pkg::job_t jb_q;
	logic [7:0]  hr_q, hg_q;
	logic        ovalid_q;
	pnm_pkg::out_item_t out_q;

	// clamp and numerator setup
	logic [15:0] clamped;
	logic [23:0] num;
	assign clamped = (job.sample > job.maxv) ? job.maxv : job.sample;
	assign num = ({8'd0, clamped} << 8) - {8'd0, clamped} + {9'd0, job.maxv[15:1]};

	// quotient fits 8 bits: restoring division, one bit per cycle
	logic [24:0] trial;
	assign trial = rem_q - ({9'd0, den_q} << cnt_q[2:0]);

	logic out_free;
	assign out_free = !ovalid_q || pop;
	assign jready = (st_q == ST_IDLE) && out_free;
	assign empty  = !ovalid_q;
	assign result = out_q;

	pnm_pkg::out_item_t nxt;
	logic nxt_v;
	always_comb begin
		nxt = '0; nxt_v = 1'b0;
		if (st_q == ST_OUT) begin
			nxt_v = jb_q.emit;
			nxt.result_kind = pnm_pkg::KIND_PIX;
			nxt.red   = jb_q.chan == 2'd2 ? hr_q : quo_q;
			nxt.green = jb_q.chan == 2'd2 ? hg_q : quo_q;
			nxt.blue  = quo_q;
			nxt.alpha = 8'd255;
			nxt.last_pixel  = jb_q.last_pix;
			nxt.last_of_run = jb_q.last_run;
		end else if (st_q == ST_IDLE && jvalid) begin
			nxt_v = job.op == pnm_pkg::OP_HDR || job.op == pnm_pkg::OP_ERR;
			nxt.result_kind = (job.op == pnm_pkg::OP_HDR) ? pnm_pkg::KIND_HDR
				: pnm_pkg::KIND_ERR;
			nxt.image_width  = job.w;
			nxt.image_height = job.h;
			nxt.error_code   = job.err;
			nxt.last_of_run  = job.last_run;
		end
	end

	// scaler sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; ovalid_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (out_free && nxt_v) ovalid_q <= 1'b1;
			else if (pop && ovalid_q) ovalid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (jvalid && out_free && job.op == pnm_pkg::OP_SAMP) begin
						st_q <= ST_DIV; cnt_q <= 4'd7;
					end
				end
				ST_DIV: begin
					if (cnt_q == 4'd0) st_q <= ST_OUT;
					else cnt_q <= cnt_q - 4'd1;
				end
				ST_OUT: begin
					if (out_free) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && jvalid && out_free) begin
			jb_q <= job; rem_q <= {1'b0, num}; den_q <= job.maxv; quo_q <= '0;
			if (nxt_v) out_q <= nxt;
		end
		if (st_q == ST_DIV) begin
			if (!trial[24] && den_q != 16'd0) begin
				rem_q <= trial; quo_q[cnt_q[2:0]] <= 1'b1;
			end
		end
		if (st_q == ST_OUT && out_free) begin
			if (jb_q.chan == 2'd0) hr_q <= quo_q;
			if (jb_q.chan == 2'd1) hg_q <= quo_q;
			if (nxt_v) out_q <= nxt;
		end
	end

endmodule

/* hw/rtl/pnm_stream_to_rgba_decoder.sv */
// top level of the pnm stream decoder: parser, job queue, scaler
// depends on pnm_pkg, pnm_front, pnm_queue, pnm_back and the macros header
//
// input queue side: push an item (file byte plus end_of_file flag) while full
// is low. output queue side: while empty is low the oldest result is on
// result; pop takes it. results are header, pixel and error items in file
// order; last_of_run marks the last result of a byte.
// a header or error result reaches result through the job queue and the
// output register; a pixel passes the job queue, an accept in the scaler,
// eight divider steps of the radix-2 restoring divider and an output state.
// the scaler takes no new sample until it has put out the current one. header
// bytes and bytes with no result go at one a cycle while the job queue has
// room; a byte with two results holds full high until its second job is taken.
// reset clears the parser, queue and output register; end_of_file returns
// the parser to its reset state. when pop stays low, the output register
// holds, the scaler then the job queue fill, and full rises.
`include "pnm_stream_to_rgba_decoder_macros.svh"
module pnm_stream_to_rgba_decoder #(
	parameter int unsigned SAMPLE_BITS = pnm_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned QDEPTH      = pnm_pkg::QDEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  pnm_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output pnm_pkg::out_item_t result
);

	logic fv, fr, bv, br;
	pnm_pkg::job_t fj, bj;

	pnm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.jvalid(fv), .jready(fr), .job(fj)
	);

	pnm_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk, .arst_n, .wvalid(fv), .wready(fr), .wdata(fj),
		.rvalid(bv), .rready(br), .rdata(bj)
	);

	pnm_back u_back (
		.clk, .arst_n, .jvalid(bv), .jready(br), .job(bj),
		.empty, .pop, .result
	);

	// checks
	logic out_pix, out_err;
	assign out_pix = !empty && result.result_kind == pnm_pkg::KIND_PIX;
	assign out_err = !empty && result.result_kind == pnm_pkg::KIND_ERR;

	`PNM_ASSERT_IMP(a_alpha, clk, arst_n, out_pix, result.alpha == 8'd255, "pixel alpha not 255")
	`PNM_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(result), "stall moved")
	`PNM_ASSERT_IMP(a_err, clk, arst_n, out_err, result.error_code != pnm_pkg::ERR_NONE, "no code")

endmodule
